/* rtl/imc_pkg.sv */
package imc_pkg;

   localparam int unsigned IP_W  = 32;
   localparam int unsigned MAC_W = 48;

   // request kinds carried on req_tuser
   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef logic [IP_W-1:0]  ip_type;
   typedef logic [MAC_W-1:0] mac_type;

endpackage

/* rtl/ip_to_mac_cache_round_robin.sv */
// Channel | Dir | tdata (low bit up)                  | tuser
// --------+-----+-------------------------------------+----------------------------
// req_    | in  | ip_addr[31:0], new_mac[79:32]       | req_type (0 update, 1 lookup)
// rsp_    | out | mac_out[47:0]                       | hit
//
// One comparator walks the filled entries in turn: the key memory is read at the scan
// index and the registered word is compared against the requested address. The scan stops
// at the first match, else covers all filled entries; an update then writes the table,
// and a lookup emits its result. The block takes one request at a time.
// A lookup result waits in the output register while the next request is accepted;
// only a second lookup stalls, at its last step, until that result has been taken.
// Synchronous reset empties the table at once (fill count and victim pointer to zero).
module ip_to_mac_cache_round_robin
   import imc_pkg::*;
#(
   parameter int unsigned ENTRIES = 8
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [79:0]        req_tdata,   // ip_addr[31:0], new_mac[79:32]
   input  logic               req_tuser,   // req_type

   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [47:0]        rsp_tdata,   // mac_out[47:0]
   output logic               rsp_tuser    // hit
);

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_RESOLVE,
      ST_EMIT
   } state_type;

   state_type           state_ff,  state_in;
   logic [IDX_W-1:0]    idx_ff,    idx_in;
   logic [IDX_W-1:0]    slot_ff,   slot_in;
   logic                found_ff,  found_in;
   logic [CNT_W-1:0]    fill_ff,   fill_in;
   logic [IDX_W-1:0]    victim_ff, victim_in;
   logic                op_ff,     op_in;
   ip_type              ip_ff,     ip_in;
   mac_type             new_mac_ff, new_mac_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff,   rsp_hit_in;
   mac_type             rsp_mac_ff,   rsp_mac_in;

   ip_type              key_mem_ff [ENTRIES];
   mac_type             mac_mem_ff [ENTRIES];
   ip_type              key_rd_ff;
   mac_type             mac_rd_ff;

   logic                full;
   logic                idx_last;
   logic                mem_we;
   logic [IDX_W-1:0]    wr_slot;

   assign full     = (fill_ff == CNT_W'(ENTRIES));
   assign idx_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == fill_ff);
   assign wr_slot  = found_ff ? slot_ff : (full ? victim_ff : fill_ff[IDX_W-1:0]);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_mac_ff;
   assign rsp_tuser  = rsp_hit_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      found_in     = found_ff;
      fill_in      = fill_ff;
      victim_in    = victim_ff;
      op_in        = op_ff;
      ip_in        = ip_ff;
      new_mac_in   = new_mac_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_mac_in   = rsp_mac_ff;
      mem_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in      = req_tuser;
               ip_in      = req_tdata[IP_W-1:0];
               new_mac_in = req_tdata[IP_W +: MAC_W];
               idx_in     = '0;
               found_in   = 1'b0;
               // empty table: nothing to scan
               state_in   = (fill_ff == '0) ? ST_RESOLVE : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (key_rd_ff == ip_ff) begin
               found_in = 1'b1;
               slot_in  = idx_ff;
               state_in = ST_RESOLVE;
            end else if (idx_last) begin
               state_in = ST_RESOLVE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_READ;
            end
         end
         ST_RESOLVE: begin
            if (op_ff == REQ_LOOKUP) begin
               state_in = ST_EMIT;
            end else begin
               mem_we   = 1'b1;
               state_in = ST_IDLE;
               if (!found_ff) begin
                  if (!full) begin
                     fill_in = fill_ff + CNT_W'(1);
                  end else begin
                     victim_in = (victim_ff == IDX_W'(ENTRIES - 1)) ? '0
                                                                     : victim_ff + IDX_W'(1);
                  end
               end
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = found_ff;
               rsp_mac_in   = found_ff ? mac_rd_ff : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      slot_ff    <= slot_in;
      found_ff   <= found_in;
      op_ff      <= op_in;
      ip_ff      <= ip_in;
      new_mac_ff <= new_mac_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_mac_ff <= rsp_mac_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         victim_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         victim_ff    <= victim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // table storage: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (mem_we) begin
         if (!found_ff) begin
            key_mem_ff[wr_slot] <= ip_ff;
         end
         mac_mem_ff[wr_slot] <= new_mac_ff;
      end
      key_rd_ff <= key_mem_ff[idx_ff];
      mac_rd_ff <= mac_mem_ff[slot_ff];
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
   import imc_pkg::*;

   localparam int ENTRIES     = 8;
   localparam int DIR_N       = 20;
   localparam int RAND_N      = 500;
   localparam int POOL_N      = 12;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN       = 40;
   localparam int LIMIT       = 200000;

   typedef struct {
      logic    kind;
      ip_type  ip;
      mac_type mac;
      bit      typed;
      bit      found;
      mac_type mac_exp;
   } dir_row_type;

   typedef struct {
      bit      found;
      mac_type mac;
   } lookup_rsp_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;   // ip_addr[31:0], new_mac[79:32]
   logic        req_tuser  = 1'b0; // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // mac_out[47:0]
   logic        rsp_tuser;         // hit

   // shadow copy of the cache contents
   ip_type  key_tab [ENTRIES];
   mac_type mac_tab [ENTRIES];
   int      fill_cnt = 0;
   int      victim   = 0;

   lookup_rsp_type expected_lookups [$];
   ip_type         key_pool [POOL_N];

   int err_count   = 0;
   int rsp_seen    = 0;
   int cycle_count = 0;
   int burst_left  = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;
   int pat_phase   = 0;
   logic [15:0] ready_pat = '1;

   // extremes first, then fill the table and force two evictions
   dir_row_type dir_tab [DIR_N] = '{
      '{REQ_LOOKUP, 32'h0000_0000, 48'hA5A5_A5A5_A5A5, 1'b1, 1'b0, 48'h0},
      '{REQ_UPDATE, 32'h0000_0000, 48'h0000_0000_0000, 1'b0, 1'b0, 48'h0},
      '{REQ_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 48'h0},
      '{REQ_UPDATE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 48'h0},
      '{REQ_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF},
      '{REQ_UPDATE, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 48'h0},
      '{REQ_LOOKUP, 32'h0000_0000, 48'h5A5A_5A5A_5A5A, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF},
      '{REQ_LOOKUP, 32'h1234_5678, 48'h0000_0000_0000, 1'b1, 1'b0, 48'h0},
      '{REQ_UPDATE, 32'h0A00_0002, 48'h0200_0000_0002, 1'b0, 1'b0, 48'h0},
      '{REQ_UPDATE, 32'h0A00_0003, 48'h0200_0000_0003, 1'b0, 1'b0, 48'h0},
      '{REQ_UPDATE, 32'h0A00_0004, 48'h0200_0000_0004, 1'b0, 1'b0, 48'h0},
      '{REQ_UPDATE, 32'h0A00_0005, 48'h0200_0000_0005, 1'b0, 1'b0, 48'h0},
      '{REQ_UPDATE, 32'h0A00_0006, 48'h0200_0000_0006, 1'b0, 1'b0, 48'h0},
      '{REQ_UPDATE, 32'h0A00_0007, 48'h0200_0000_0007, 1'b0, 1'b0, 48'h0},
      '{REQ_UPDATE, 32'h0A00_0008, 48'h0200_0000_0008, 1'b0, 1'b0, 48'h0},
      '{REQ_LOOKUP, 32'h0000_0000, 48'h0000_0000_0000, 1'b0, 1'b0, 48'h0},
      '{REQ_LOOKUP, 32'h0A00_0008, 48'h0000_0000_0000, 1'b0, 1'b0, 48'h0},
      '{REQ_UPDATE, 32'h0A00_0009, 48'h0200_0000_0009, 1'b0, 1'b0, 48'h0},
      '{REQ_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b0, 1'b0, 48'h0},
      '{REQ_LOOKUP, 32'h0A00_0007, 48'h0000_0000_0000, 1'b0, 1'b0, 48'h0}
   };

   ip_to_mac_cache_round_robin #(
      .ENTRIES(ENTRIES)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // apply one request to the shadow table; lookups yield a response
   function automatic void cache_access(input logic kind, input ip_type ip, input mac_type mac,
                                        output bit has_rsp, output lookup_rsp_type rsp);
      int slot;
      slot = ENTRIES;
      for (int i = 0; i < fill_cnt; i++)
         if (slot == ENTRIES && key_tab[i] == ip) slot = i;
      has_rsp = (kind == REQ_LOOKUP);
      rsp = '{found: 1'b0, mac: '0};
      if (kind == REQ_UPDATE) begin
         if (slot == ENTRIES) begin
            if (fill_cnt < ENTRIES) begin
               slot = fill_cnt;
               fill_cnt++;
            end else begin
               slot = victim;
               victim = (victim + 1) % ENTRIES;
            end
            key_tab[slot] = ip;
         end
         mac_tab[slot] = mac;
      end else if (slot != ENTRIES) begin
         rsp = '{found: 1'b1, mac: mac_tab[slot]};
      end
   endfunction

   // offer one transaction, idling between bursts; called just after the clock rises
   task automatic offer_req(input logic kind, input ip_type ip, input mac_type mac,
                            input bit typed, input bit t_found, input mac_type t_mac);
      int             gap;
      bit             has_rsp;
      lookup_rsp_type rsp;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {mac, ip};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      cache_access(kind, ip, mac, has_rsp, rsp);
      if (has_rsp) begin
         if (typed) rsp = '{found: t_found, mac: t_mac};
         expected_lookups.push_back(rsp);
      end
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      lookup_rsp_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_seen++;
            if (expected_lookups.size() == 0) begin
               err_count++;
               if (err_count <= 10)
                  $display("unexpected response: hit=%0b mac=%012h", rsp_tuser, rsp_tdata);
            end else begin
               want = expected_lookups.pop_front();
               if (rsp_tuser !== want.found || rsp_tdata !== want.mac) begin
                  err_count++;
                  if (err_count <= 10)
                     $display("response %0d: expected hit=%0b mac=%012h, got hit=%0b mac=%012h",
                              rsp_seen, want.found, want.mac, rsp_tuser, rsp_tdata);
               end
            end
         end
      end
   end

   // receiver: ready pattern, with one long hold so the input backs up
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_seen >= 60 && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (pat_phase == 0)
               ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            pat_phase = (pat_phase + 1) % 32;
            rsp_tready <= ready_pat[pat_phase % 16];
         end
      end
   end

   initial begin
      ip_type      rnd_ip;
      logic [63:0] rnd_word;
      logic        rnd_kind;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i])
         offer_req(dir_tab[i].kind, dir_tab[i].ip, dir_tab[i].mac,
                   dir_tab[i].typed, dir_tab[i].found, dir_tab[i].mac_exp);

      // a small key pool keeps hits, overwrites and evictions frequent
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_N; i++) key_pool[i] = $urandom;

      for (int n = 0; n < RAND_N; n++) begin
         rnd_kind = $urandom_range(0, 1) ? REQ_LOOKUP : REQ_UPDATE;
         if ($urandom_range(0, 7) == 0) rnd_ip = $urandom;
         else rnd_ip = key_pool[$urandom_range(0, POOL_N - 1)];
         rnd_word = {$urandom, $urandom};
         offer_req(rnd_kind, rnd_ip, rnd_word[47:0], 1'b0, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (expected_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (err_count == 0 && expected_lookups.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/imc_pkg.sv
rtl/ip_to_mac_cache_round_robin.sv
tb/testbench.sv
